// ----- rtl/sstf_pkg.sv -----
package sstf_pkg;

   localparam int QUEUE_DEPTH   = 1024;
   localparam int CYLINDER_BITS = 13;
   localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_BITS    = 23;
   localparam int COUNT_BITS    = 11;
   localparam int ENTRY_BITS    = CYLINDER_BITS + 1;
   localparam int REQ_DATA_BITS = ((CYLINDER_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((TOTAL_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;

   typedef enum logic [2:0] {
      STEP_LOAD,
      STEP_BATCH,
      STEP_ROUND,
      STEP_SCAN,
      STEP_DRAIN,
      STEP_COMMIT,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_LAST,
      COND_SCAN_END,
      COND_ROUND_END,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     load;
      logic     init_batch;
      logic     init_round;
      logic     scan;
      logic     commit;
      logic     emit;
      cond_type cond;
      step_type go_true;
      step_type go_false;
   } ctl_type;

   typedef struct packed {
      logic last_fire;
      logic scan_end;
      logic round_end;
      logic out_free;
   } stat_type;

   // Microprogram: one control word per step.
   function automatic ctl_type ucode_rom(step_type step);
      ctl_type w;
      w = '{load: 1'b0, init_batch: 1'b0, init_round: 1'b0, scan: 1'b0, commit: 1'b0,
            emit: 1'b0, cond: COND_ALWAYS, go_true: STEP_LOAD, go_false: STEP_LOAD};
      unique case (step)
         STEP_LOAD: begin
            w.load = 1'b1;
            w.cond = COND_LAST;
            w.go_true = STEP_BATCH;
            w.go_false = STEP_LOAD;
         end
         STEP_BATCH: begin
            w.init_batch = 1'b1;
            w.go_true = STEP_ROUND;
            w.go_false = STEP_ROUND;
         end
         STEP_ROUND: begin
            w.init_round = 1'b1;
            w.go_true = STEP_SCAN;
            w.go_false = STEP_SCAN;
         end
         STEP_SCAN: begin
            w.scan = 1'b1;
            w.cond = COND_SCAN_END;
            w.go_true = STEP_DRAIN;
            w.go_false = STEP_SCAN;
         end
         STEP_DRAIN: begin
            w.go_true = STEP_COMMIT;
            w.go_false = STEP_COMMIT;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.cond = COND_ROUND_END;
            w.go_true = STEP_EMIT;
            w.go_false = STEP_ROUND;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_OUT_FREE;
            w.go_true = STEP_LOAD;
            w.go_false = STEP_EMIT;
         end
         default: begin
            w.go_true = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/sstf_ram.sv -----
module sstf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sstf_useq.sv -----
module sstf_useq
   import sstf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   step_type upc_ff;
   step_type upc_in;
   logic     take;

   assign ctl = ucode_rom(upc_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_ALWAYS:    take = 1'b1;
         COND_LAST:      take = stat.last_fire;
         COND_SCAN_END:  take = stat.scan_end;
         COND_ROUND_END: take = stat.round_end;
         COND_OUT_FREE:  take = stat.out_free;
         default:        take = 1'b1;
      endcase
      upc_in = take ? ctl.go_true : ctl.go_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- rtl/sstf_dpath.sv -----
module sstf_dpath
   import sstf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  ctl,
   output stat_type                 stat,
   input  logic [CYLINDER_BITS-1:0] start_head,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CYLINDER_BITS-1:0] req_cylinder,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [TOTAL_BITS-1:0]    rsp_total,
   output logic [COUNT_BITS-1:0]    rsp_count,
   output logic                     rsp_overflow
);

   logic [CNT_BITS-1:0]      loaded_ff, loaded_in;
   logic                     dropped_ff, dropped_in;
   logic [CNT_BITS-1:0]      k_ff, k_in;
   logic [CNT_BITS-1:0]      round_ff, round_in;
   logic [CYLINDER_BITS-1:0] head_ff, head_in;
   logic [TOTAL_BITS-1:0]    total_ff, total_in;
   logic                     found_ff, found_in;
   logic [CYLINDER_BITS-1:0] best_ff, best_in;
   logic [CYLINDER_BITS-1:0] best_cyl_ff, best_cyl_in;
   logic [IDX_BITS-1:0]      pick_ff, pick_in;
   logic                     rd_valid_ff;
   logic [IDX_BITS-1:0]      rd_idx_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_BITS-1:0]    rsp_total_ff, rsp_total_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     req_fire;
   logic                     store_full;
   logic                     out_free;
   logic                     emit_fire;
   logic                     wr_en;
   logic [IDX_BITS-1:0]      wr_addr;
   logic [ENTRY_BITS-1:0]    wr_data;
   logic [ENTRY_BITS-1:0]    rd_data;
   logic                     rd_served;
   logic [CYLINDER_BITS-1:0] rd_cyl;
   logic [CYLINDER_BITS-1:0] seek_len;
   logic                     better;
   logic [TOTAL_BITS:0]      sum;

   // Entry layout: served mark above the cylinder.
   sstf_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (ctl.scan),
      .rd_addr(k_ff[IDX_BITS-1:0]),
      .rd_data(rd_data)
   );

   assign req_tready = ctl.load;
   assign req_fire   = req_tvalid && req_tready;
   assign store_full = (32'(loaded_ff) >= QUEUE_DEPTH);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = ctl.emit && out_free;

   assign rd_served = rd_data[ENTRY_BITS-1];
   assign rd_cyl    = rd_data[CYLINDER_BITS-1:0];
   assign seek_len  = (head_ff >= rd_cyl) ? (head_ff - rd_cyl) : (rd_cyl - head_ff);
   assign better    = rd_valid_ff && !rd_served && (!found_ff || (seek_len < best_ff));
   assign sum       = {1'b0, total_ff} + (TOTAL_BITS + 1)'(best_ff);

   assign stat.last_fire = req_fire && req_tlast;
   assign stat.scan_end  = (k_ff == loaded_ff - CNT_BITS'(1));
   assign stat.round_end = (round_ff == loaded_ff - CNT_BITS'(1));
   assign stat.out_free  = out_free;

   always_comb begin
      loaded_in    = loaded_ff;
      dropped_in   = dropped_ff;
      k_in         = k_ff;
      round_in     = round_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_cyl_in  = best_cyl_ff;
      pick_in      = pick_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = loaded_ff[IDX_BITS-1:0];
      wr_data      = {1'b0, req_cylinder};

      if (req_fire) begin
         if (store_full) begin
            dropped_in = 1'b1;
         end else begin
            wr_en     = 1'b1;
            loaded_in = loaded_ff + CNT_BITS'(1);
         end
      end
      if (ctl.init_batch) begin
         head_in  = start_head;
         total_in = '0;
         round_in = '0;
      end
      if (ctl.init_round) begin
         k_in     = '0;
         found_in = 1'b0;
      end
      if (ctl.scan) begin
         k_in = k_ff + CNT_BITS'(1);
      end
      // Strict compare keeps the earliest loaded request on a tie.
      if (better) begin
         found_in    = 1'b1;
         best_in     = seek_len;
         best_cyl_in = rd_cyl;
         pick_in     = rd_idx_ff;
      end
      if (ctl.commit) begin
         wr_en    = 1'b1;
         wr_addr  = pick_ff;
         wr_data  = {1'b1, best_cyl_ff};
         head_in  = best_cyl_ff;
         total_in = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
         round_in = round_ff + CNT_BITS'(1);
      end
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = total_ff;
         rsp_count_in = (32'(loaded_ff) > COUNT_MAX) ? '1 : COUNT_BITS'(loaded_ff);
         rsp_ovf_in   = dropped_ff;
         loaded_in    = '0;
         dropped_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         dropped_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         dropped_ff   <= dropped_in;
         rd_valid_ff  <= ctl.scan;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      round_ff     <= round_in;
      head_ff      <= head_in;
      total_ff     <= total_in;
      best_ff      <= best_in;
      best_cyl_ff  <= best_cyl_in;
      pick_ff      <= pick_in;
      rd_idx_ff    <= k_ff[IDX_BITS-1:0];
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_total    = rsp_total_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_commit_found: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> found_ff && !rd_valid_ff)
      else $error("commit without a drained candidate");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.scan |-> loaded_ff != '0)
      else $error("scan over an empty store");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> loaded_ff == '0 && !dropped_ff && rsp_valid_ff)
      else $error("batch state not cleared after result");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> total_ff >= $past(total_ff))
      else $error("total movement decreased");

endmodule

// ----- rtl/sstf_seek_total.sv -----
// Shortest-seek-time-first scheduler: total head movement of one batch.
//
// Input channel req_*: one cylinder request per transaction, tlast marks the
// final request of a batch. Requests load at one per cycle while loading;
// past the store depth they are dropped and the batch result flags overflow.
// csr_we / csr_wdata set the start head cylinder; write it only while idle.
//
// After the last request, a microcoded sequencer scans the store once per
// served request through the single read port of the request memory. With
// n requests stored the schedule runs n rounds, then one result transaction
// appears on rsp_* (total movement, count, overflow).
// req_tready stays low from the last request until the result has been
// handed to the output register.
//
// The output register holds the result while rsp_tready is low; the block
// returns to loading right away and only stalls again if the next batch's
// result is ready before the previous one is taken.
// Reset clears the batch count, flags and output valid; no memory sweep.
module sstf_seek_total
   import sstf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CYLINDER_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [12:0] cylinder
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [22:0] total_movement, [33:23] served_count
   output logic                     rsp_tuser    // overflow
);

   logic [CYLINDER_BITS-1:0] start_head_ff;
   ctl_type                  ctl;
   stat_type                 stat;
   logic [TOTAL_BITS-1:0]    rsp_total;
   logic [COUNT_BITS-1:0]    rsp_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= '0;
      end else if (csr_we) begin
         start_head_ff <= csr_wdata;
      end
   end

   sstf_useq u_useq (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .ctl  (ctl)
   );

   sstf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stat        (stat),
      .start_head  (start_head_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_cylinder(req_tdata[CYLINDER_BITS-1:0]),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_total   (rsp_total),
      .rsp_count   (rsp_count),
      .rsp_overflow(rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_count, rsp_total});

endmodule
